// ----- rtl/box_centroid_tracker_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef BOX_CENTROID_TRACKER_MACROS_SVH
`define BOX_CENTROID_TRACKER_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define BCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger.
`define BCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bct_pkg.sv -----
package bct_pkg;

   // Box coordinate width
   localparam int COORD_BITS = 12;

   // Configuration register widths
   localparam int DIST_W      = 12;
   localparam int SPEED_LIM_W = 31;
   localparam int SIZE_LIM_W  = 13;
   localparam int MISS_LIM_W  = 4;
   localparam int FW_W        = 13;
   localparam int INV_W       = 16;

   // State widths
   localparam int DIAG_W  = COORD_BITS + 1;
   localparam int SPEED_W = 32;
   localparam int MISS_W  = 5;
   localparam logic [MISS_W-1:0] MISS_MAX = {MISS_W{1'b1}};

   // Square root radicand: sum of two squares of COORD_BITS+1 bit differences
   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int SUM_W = 2 * COORD_BITS + 1;

   // Shared multiplier operand widths
   localparam int MUL_A_W = ((COORD_BITS > FW_W) ? COORD_BITS : FW_W) + 2;
   localparam int MUL_B_W = INV_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Stream widths
   localparam int MODE_W     = 2;
   localparam int REQ_USER_W = MODE_W;
   localparam int REQ_BITS   = 4 * COORD_BITS;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;

   localparam int RSP_MATCHED  = 0;
   localparam int RSP_LOST     = 1;
   localparam int RSP_MOVING   = 2;
   localparam int RSP_X_LO     = 3;
   localparam int RSP_Y_LO     = RSP_X_LO + COORD_BITS;
   localparam int RSP_SPEED_LO = RSP_Y_LO + COORD_BITS;
   localparam int RSP_SIZE_LO  = RSP_SPEED_LO + SPEED_W;
   localparam int RSP_BITS     = RSP_SIZE_LO + DIAG_W;
   localparam int RSP_DATA_W   = ((RSP_BITS + 7) / 8) * 8;

   // Register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_DIST_X     = 3'd0,
      REG_DIST_Y     = 3'd1,
      REG_SPEED_LIM  = 3'd2,
      REG_SIZE_LIM   = 3'd3,
      REG_MISS_LIM   = 3'd4,
      REG_FRAME_W    = 3'd5,
      REG_INV_PERIOD = 3'd6
   } bct_reg_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_START  = 2'd0,
      MODE_QUERY  = 2'd1,
      MODE_UPDATE = 2'd2,
      MODE_MISS   = 2'd3
   } bct_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_VEL,
      ST_ROOT,
      ST_WAIT,
      ST_COMMIT,
      ST_OUT
   } bct_state_type;

   typedef struct packed {
      logic [DIST_W-1:0]      dist_x_limit;
      logic [DIST_W-1:0]      dist_y_limit;
      logic [SPEED_LIM_W-1:0] speed_limit;
      logic [SIZE_LIM_W-1:0]  size_limit;
      logic [MISS_LIM_W-1:0]  miss_limit;
      logic [FW_W-1:0]        frame_width;
      logic [INV_W-1:0]       inverse_period;
   } bct_cfg_type;

   localparam bct_cfg_type CFG_RESET = '{
      dist_x_limit:   DIST_W'(200),
      dist_y_limit:   DIST_W'(20),
      speed_limit:    SPEED_LIM_W'(512),
      size_limit:     SIZE_LIM_W'(100),
      miss_limit:     MISS_LIM_W'(5),
      frame_width:    FW_W'(1920),
      inverse_period: INV_W'(2560)
   };

   // Clamp a product to the signed speed range
   function automatic logic signed [SPEED_W-1:0] sat_speed(
      input logic signed [PROD_W-1:0] v
   );
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = {{(PROD_W-SPEED_W+1){1'b0}}, {(SPEED_W-1){1'b1}}};
      lo = {{(PROD_W-SPEED_W+1){1'b1}}, {(SPEED_W-1){1'b0}}};
      if (v > hi) begin
         sat_speed = hi[SPEED_W-1:0];
      end else if (v < lo) begin
         sat_speed = lo[SPEED_W-1:0];
      end else begin
         sat_speed = v[SPEED_W-1:0];
      end
   endfunction

endpackage

// ----- rtl/bct_csr.sv -----
module bct_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bct_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bct_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bct_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output bct_pkg::bct_cfg_type            cfg
);
   import bct_pkg::*;

   bct_cfg_type            cfg_ff;
   bct_cfg_type            cfg_in;
   logic [REG_IDX_W-1:0]   idx;
   logic                   wr;

   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register writes, access phase only
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_DIST_X:     cfg_in.dist_x_limit   = csr_pwdata[DIST_W-1:0];
            REG_DIST_Y:     cfg_in.dist_y_limit   = csr_pwdata[DIST_W-1:0];
            REG_SPEED_LIM:  cfg_in.speed_limit    = csr_pwdata[SPEED_LIM_W-1:0];
            REG_SIZE_LIM:   cfg_in.size_limit     = csr_pwdata[SIZE_LIM_W-1:0];
            REG_MISS_LIM:   cfg_in.miss_limit     = csr_pwdata[MISS_LIM_W-1:0];
            REG_FRAME_W:    cfg_in.frame_width    = csr_pwdata[FW_W-1:0];
            REG_INV_PERIOD: cfg_in.inverse_period = csr_pwdata[INV_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back
   always_comb begin
      case (idx)
         REG_DIST_X:     csr_prdata = CSR_DATA_W'(cfg_ff.dist_x_limit);
         REG_DIST_Y:     csr_prdata = CSR_DATA_W'(cfg_ff.dist_y_limit);
         REG_SPEED_LIM:  csr_prdata = CSR_DATA_W'(cfg_ff.speed_limit);
         REG_SIZE_LIM:   csr_prdata = CSR_DATA_W'(cfg_ff.size_limit);
         REG_MISS_LIM:   csr_prdata = CSR_DATA_W'(cfg_ff.miss_limit);
         REG_FRAME_W:    csr_prdata = CSR_DATA_W'(cfg_ff.frame_width);
         REG_INV_PERIOD: csr_prdata = CSR_DATA_W'(cfg_ff.inverse_period);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// ----- rtl/bct_isqrt.sv -----
module bct_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bct_pkg::SUM_W-1:0]   radicand,
   output logic                        done,
   output logic [bct_pkg::DIAG_W-1:0]  root
);
   import bct_pkg::*;

   // Bit-pair restoring square root, one result bit per cycle
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SUM_W-1:0]   n_ff, n_in;
   logic [SUM_W-1:0]   res_ff, res_in;
   logic [SUM_W-1:0]   bit_ff, bit_in;
   logic [SUM_W:0]     trial;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign done  = done_ff;
   assign root  = res_ff[DIAG_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         n_in    = radicand;
         res_in  = '0;
         bit_in  = {1'b1, {(SUM_W-1){1'b0}}};
      end else if (busy_ff) begin
         if ({1'b0, n_ff} >= trial) begin
            n_in   = n_ff - trial[SUM_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // lowest bit pair finishes the root
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

endmodule

// ----- rtl/box_centroid_tracker.sv -----
// Channel   Direction  Handshake            Contents
// req_*     in         tvalid/tready        box corners (tdata), mode (tuser)
// rsp_*     out        tvalid/tready        flags and stored track (tdata)
// csr_*     in         APB setup/access     seven limit and timing registers
//
// One item at a time: req_tready is high only while the sequencer is idle.
// A box item makes three passes through the shared multiplier (dx squared,
// dy squared, velocity), then COORD_BITS+1 root iterations, before its result
// is offered. A missed-frame item goes straight to the commit. A stalled result
// holds the block busy.
// Synchronous active-high reset clears the track and loads register defaults.
module box_centroid_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // left_x, top_y, right_x, bottom_y (from bit 0 up)
   input  logic [bct_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode
   input  logic [bct_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // matched, lost, moving_positive, track_x, track_y, track_speed,
   // track_size (from bit 0 up)
   output logic [bct_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bct_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bct_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bct_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import bct_pkg::*;

   localparam int C = COORD_BITS;

   bct_cfg_type                cfg;

   bct_state_type              state_ff, state_in;
   bct_mode_type               mode_ff, mode_in;
   logic [C-1:0]               lx_ff, lx_in, ty_ff, ty_in;
   logic [C-1:0]               rx_ff, rx_in, by_ff, by_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;

   logic [C-1:0]               center_x_ff, center_x_in;
   logic [C-1:0]               center_y_ff, center_y_in;
   logic signed [SPEED_W-1:0]  speed_ff, speed_in;
   logic [DIAG_W-1:0]          diag_ff, diag_in;
   logic [MISS_W-1:0]          missed_ff, missed_in;
   logic                       matched_ff, matched_in;

   logic                       req_acc;
   logic                       root_start;
   logic                       root_done;
   logic [DIAG_W-1:0]          root_val;

   logic [C:0]                 xsum, ysum;
   logic [C-1:0]               cx, cy;
   logic signed [C:0]          dx, dy;
   logic                       ctr_zero;
   logic                       keep_speed;
   logic [MUL_A_W-1:0]         cx_w, ctr_w, fw_w;
   logic signed [MUL_A_W-1:0]  vel_opd;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [SPEED_W-1:0]  vel_new;
   logic [C-1:0]               adx, ady;
   logic [DIAG_W-1:0]          ads;
   logic signed [SPEED_W:0]    sp_diff;
   logic [SPEED_W:0]           sp_abs;
   logic                       far;
   logic                       moving;
   logic                       lost;

   bct_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bct_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sum_ff),
      .done     (root_done),
      .root     (root_val)
   );

   assign req_acc = req_tvalid & req_tready;

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (bct_mode_type'(req_tuser[MODE_W-1:0]) == MODE_MISS) begin
                  state_in = ST_COMMIT;
               end else begin
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX:    state_in = ST_SQY;
         ST_SQY:    state_in = ST_VEL;
         ST_VEL:    state_in = ST_ROOT;
         ST_ROOT:   state_in = ST_WAIT;
         ST_WAIT: begin
            if (root_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer: outputs and multiplier operand select
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      root_start = 1'b0;
      mul_a      = vel_opd;
      mul_b      = $signed({1'b0, cfg.inverse_period});
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_SQX: begin
            mul_a = MUL_A_W'(dx);
            mul_b = MUL_B_W'(dx);
         end
         ST_SQY: begin
            mul_a = MUL_A_W'(dy);
            mul_b = MUL_B_W'(dy);
         end
         ST_ROOT: root_start = 1'b1;
         ST_OUT:  rsp_tvalid = 1'b1;
         default: begin
         end
      endcase
   end

   // Observation from the captured corners
   assign xsum = {1'b0, lx_ff} + {1'b0, rx_ff};
   assign ysum = {1'b0, ty_ff} + {1'b0, by_ff};
   assign cx   = xsum[C:1];
   assign cy   = ysum[C:1];
   assign dx   = $signed({1'b0, rx_ff}) - $signed({1'b0, lx_ff});
   assign dy   = $signed({1'b0, by_ff}) - $signed({1'b0, ty_ff});

   // Velocity operand: x change, or offset from the nearer frame edge
   assign ctr_zero   = (mode_ff == MODE_START) || (center_x_ff == '0);
   assign keep_speed = !ctr_zero && (cx == center_x_ff);
   assign cx_w       = MUL_A_W'(cx);
   assign ctr_w      = MUL_A_W'(center_x_ff);
   assign fw_w       = MUL_A_W'(cfg.frame_width);

   always_comb begin
      if (!ctr_zero) begin
         vel_opd = cx_w - ctr_w;
      end else if (cx_w > (fw_w >> 1)) begin
         vel_opd = cx_w - fw_w;
      end else begin
         vel_opd = cx_w;
      end
   end

   assign prod_in = mul_a * mul_b;

   // Partial sums of the squared differences
   always_comb begin
      sum_in = sum_ff;
      case (state_ff)
         ST_SQY:  sum_in = SUM_W'(prod_ff[SQ_W-1:0]);
         ST_VEL:  sum_in = sum_ff + SUM_W'(prod_ff[SQ_W-1:0]);
         default: sum_in = sum_ff;
      endcase
   end

   // Match test against the stored track
   assign vel_new = keep_speed ? speed_ff : sat_speed(prod_ff);
   assign adx     = (cx > center_x_ff) ? cx - center_x_ff : center_x_ff - cx;
   assign ady     = (cy > center_y_ff) ? cy - center_y_ff : center_y_ff - cy;
   assign ads     = (root_val > diag_ff) ? root_val - diag_ff : diag_ff - root_val;
   assign sp_diff = $signed({vel_new[SPEED_W-1], vel_new})
                  - $signed({speed_ff[SPEED_W-1], speed_ff});
   assign sp_abs  = sp_diff[SPEED_W] ? (~sp_diff + 1'b1) : sp_diff;
   assign far     = (32'(adx) > 32'(cfg.dist_x_limit))
                 && (32'(ady) > 32'(cfg.dist_y_limit))
                 && (sp_abs > (SPEED_W+1)'(cfg.speed_limit))
                 && (32'(ads) > 32'(cfg.size_limit));

   // Item capture and track update
   always_comb begin
      mode_in     = mode_ff;
      lx_in       = lx_ff;
      ty_in       = ty_ff;
      rx_in       = rx_ff;
      by_in       = by_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      speed_in    = speed_ff;
      diag_in     = diag_ff;
      missed_in   = missed_ff;
      matched_in  = matched_ff;
      if (req_acc) begin
         mode_in = bct_mode_type'(req_tuser[MODE_W-1:0]);
         lx_in   = req_tdata[0 +: C];
         ty_in   = req_tdata[C +: C];
         rx_in   = req_tdata[2*C +: C];
         by_in   = req_tdata[3*C +: C];
      end
      if (state_ff == ST_COMMIT) begin
         matched_in = 1'b0;
         case (mode_ff)
            MODE_START, MODE_UPDATE: begin
               center_x_in = cx;
               center_y_in = cy;
               speed_in    = vel_new;
               diag_in     = root_val;
               missed_in   = '0;
            end
            MODE_QUERY: matched_in = !far;
            MODE_MISS: begin
               if (missed_ff != MISS_MAX) begin
                  missed_in = missed_ff + 1'b1;
               end
            end
            default: matched_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         center_x_ff <= '0;
         center_y_ff <= '0;
         speed_ff    <= '0;
         diag_ff     <= '0;
         missed_ff   <= '0;
         matched_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         speed_ff    <= speed_in;
         diag_ff     <= diag_in;
         missed_ff   <= missed_in;
         matched_ff  <= matched_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      lx_ff   <= lx_in;
      ty_ff   <= ty_in;
      rx_ff   <= rx_in;
      by_ff   <= by_in;
      sum_ff  <= sum_in;
      if (state_ff == ST_SQX || state_ff == ST_SQY || state_ff == ST_VEL) begin
         prod_ff <= prod_in;
      end
   end

   // Result item from the stored track
   assign moving = !speed_ff[SPEED_W-1] && (speed_ff != '0);
   assign lost   = MISS_W'(cfg.miss_limit) < missed_ff;

   assign rsp_tdata = RSP_DATA_W'({diag_ff, speed_ff, center_y_ff, center_x_ff,
                                   moving, lost, matched_ff});

endmodule

// ----- rtl/bct_checker.sv -----
`include "box_centroid_tracker_macros.svh"

module bct_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bct_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import bct_pkg::*;

   logic                  req_acc;
   logic                  rsp_acc;
   logic [SPEED_W-1:0]    spd;
   logic                  mov_exp;

   assign req_acc = req_tvalid & req_tready;
   assign rsp_acc = rsp_tvalid & rsp_tready;
   assign spd     = rsp_tdata[RSP_SPEED_LO +: SPEED_W];
   assign mov_exp = !spd[SPEED_W-1] && (spd != '0);

   // never takes an item while a result is pending
   `BCT_ASSERT_NOW(a_one_item, clock, reset, rsp_tvalid, !req_tready, "ready while result pending")
   // no result in the cycle after an item is taken
   `BCT_ASSERT_NEXT(a_no_instant, clock, reset, req_acc, !rsp_tvalid, "result too early")
   // delivering the result frees the block
   `BCT_ASSERT_NEXT(a_free_after, clock, reset, rsp_acc, req_tready, "not ready after result")
   // direction flag agrees with the reported speed
   `BCT_ASSERT_NOW(a_moving, clock, reset, rsp_tvalid, rsp_tdata[RSP_MOVING] == mov_exp, "moving flag mismatch")

endmodule

bind box_centroid_tracker bct_checker u_bct_checker (.*);
